>>> src/mhpq_pkg.sv
// shared constants, codes and types of the max-heap priority queue
// no dependencies; imported by mhpq_core, max_heap_priority_queue_unit and the testbench
package mhpq_pkg;

   localparam int CAPACITY = 1024;
   localparam int KEY_W = 32;
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CHILD_W = ADDR_W + 2;
   localparam int CMD_W = 2;
   localparam int STATUS_W = 2;
   localparam int REQ_DATA_W = ((KEY_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((KEY_W + CNT_W + 7) / 8) * 8;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ_MAX = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic signed [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] value;
      logic [STATUS_W-1:0] status;
      logic [CNT_W-1:0] occupancy;
   } rsp_type;

endpackage

>>> src/mhpq_core.sv
// heap store and sift sequencer: one write port, two registered read ports
// depends on mhpq_pkg
module mhpq_core (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  mhpq_pkg::req_type req,
   output logic idle,
   output logic done,
   output mhpq_pkg::rsp_type rsp,
   input  logic take
);
   import mhpq_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EX_LOAD = 3'd1;
   localparam logic [2:0] S_RM_LOAD = 3'd2;
   localparam logic [2:0] S_UP_RD = 3'd3;
   localparam logic [2:0] S_UP_CMP = 3'd4;
   localparam logic [2:0] S_DN_RD = 3'd5;
   localparam logic [2:0] S_DN_CMP = 3'd6;
   localparam logic [2:0] S_RESP = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic signed [KEY_W-1:0] cur_ff, cur_in;
   logic signed [KEY_W-1:0] value_ff, value_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic [KEY_W-1:0] heap_mem [CAPACITY];
   logic signed [KEY_W-1:0] rd_a_ff, rd_b_ff;
   logic [ADDR_W-1:0] rd_addr_a, rd_addr_b, wr_addr;
   logic wr_en;
   logic signed [KEY_W-1:0] wr_data;

   logic [ADDR_W-1:0] parent;
   logic [CHILD_W-1:0] left, right;
   logic left_ok, right_ok, pick_left, pick_right;
   logic signed [KEY_W-1:0] best_val;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= heap_mem[rd_addr_a];
      rd_b_ff <= heap_mem[rd_addr_b];
   end

   assign parent = (pos_ff - 1'b1) >> 1;
   assign left = {1'b0, pos_ff, 1'b1};
   assign right = left + 1'b1;
   assign left_ok = left < CHILD_W'(cnt_ff);
   assign right_ok = right < CHILD_W'(cnt_ff);

   // strict compares; left wins a tie between the children
   assign pick_left = left_ok && (rd_a_ff > cur_ff);
   assign best_val = pick_left ? rd_a_ff : cur_ff;
   assign pick_right = right_ok && (rd_b_ff > best_val);

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      cur_in = cur_ff;
      value_in = value_ff;
      status_in = status_ff;
      rd_addr_a = '0;
      rd_addr_b = '0;
      wr_en = 1'b0;
      wr_addr = pos_ff;
      wr_data = cur_ff;
      idle = 1'b0;
      done = 1'b0;
      case (state_ff)
         S_IDLE: begin
            idle = 1'b1;
            if (start) begin
               value_in = '0;
               status_in = ST_OK;
               state_in = S_RESP;
               case (req.cmd)
                  CMD_INSERT: begin
                     if (cnt_ff >= CNT_W'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else begin
                        cnt_in = cnt_ff + 1'b1;
                        pos_in = cnt_ff[ADDR_W-1:0];
                        cur_in = req.key;
                        state_in = S_UP_RD;
                     end
                  end
                  CMD_EXTRACT: begin
                     if (cnt_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        rd_addr_b = ADDR_W'(cnt_ff - 1'b1);
                        cnt_in = cnt_ff - 1'b1;
                        state_in = S_EX_LOAD;
                     end
                  end
                  CMD_READ_MAX: begin
                     if (cnt_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        state_in = S_RM_LOAD;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_EX_LOAD: begin
            // root goes out, last item becomes the key to sink from the root
            value_in = rd_a_ff;
            cur_in = rd_b_ff;
            pos_in = '0;
            state_in = (cnt_ff == '0) ? S_RESP : S_DN_RD;
         end
         S_RM_LOAD: begin
            value_in = rd_a_ff;
            state_in = S_RESP;
         end
         S_UP_RD: begin
            if (pos_ff == '0) begin
               wr_en = 1'b1;
               state_in = S_RESP;
            end else begin
               rd_addr_a = parent;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (rd_a_ff >= cur_ff) begin
               state_in = S_RESP;
            end else begin
               // parent moves down into the hole
               wr_data = rd_a_ff;
               pos_in = parent;
               state_in = S_UP_RD;
            end
         end
         S_DN_RD: begin
            rd_addr_a = left[ADDR_W-1:0];
            rd_addr_b = right[ADDR_W-1:0];
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            wr_en = 1'b1;
            if (pick_right) begin
               wr_data = rd_b_ff;
               pos_in = right[ADDR_W-1:0];
               state_in = S_DN_RD;
            end else if (pick_left) begin
               wr_data = rd_a_ff;
               pos_in = left[ADDR_W-1:0];
               state_in = S_DN_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            done = 1'b1;
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
      pos_ff <= pos_in;
      cur_ff <= cur_in;
      value_ff <= value_in;
      status_ff <= status_in;
   end

   assign rsp.value = value_ff;
   assign rsp.status = status_ff;
   assign rsp.occupancy = cnt_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      start && idle && req.cmd == CMD_INSERT && cnt_ff < CNT_W'(CAPACITY)
      |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("insert did not grow the heap");
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff != S_IDLE && state_ff != S_RESP)
      else $error("store written outside a sift");
   a_sink_in_heap: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DN_CMP |-> CNT_W'(pos_ff) < cnt_ff)
      else $error("sink position beyond heap");
   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RESP && !take |=> state_ff == S_RESP && $stable(rsp))
      else $error("result changed while waiting");
`endif

endmodule

>>> src/max_heap_priority_queue_unit.sv
// Binary max-heap priority queue over signed 32-bit keys, 1024 entries. Each
// request item carries a command (insert, extract max, read max) and gives
// exactly one result item with the value, a status and the occupancy after
// the operation. One item is in work at a time. An insert moves its key up
// at most 10 heap levels and an extract sinks its key at most 9. Each sift
// level needs one read of the heap memory, which has a single write port and
// registered reads, and then a compare and write. The result waits in an
// output register, so the next item is taken while a result is still
// stalled downstream.
// depends on mhpq_pkg and mhpq_core
module max_heap_priority_queue_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [mhpq_pkg::REQ_DATA_W-1:0] req_tdata, // [31:0] key
   input  logic [mhpq_pkg::CMD_W-1:0] req_tuser,      // [1:0] cmd
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [mhpq_pkg::RSP_DATA_W-1:0] rsp_tdata, // [31:0] value, [42:32] occupancy
   output logic [mhpq_pkg::STATUS_W-1:0] rsp_tuser    // [1:0] status
);
   import mhpq_pkg::*;

   req_type req;
   rsp_type core_rsp;
   rsp_type rsp_ff, rsp_in;
   logic rsp_tvalid_ff, rsp_tvalid_in;
   logic core_idle, core_done, core_take, start;

   assign req.cmd = req_tuser;
   assign req.key = req_tdata[KEY_W-1:0];
   assign req_tready = core_idle;
   assign start = req_tvalid && core_idle;

   mhpq_core u_core (
      .clock (clock),
      .reset (reset),
      .start (start),
      .req   (req),
      .idle  (core_idle),
      .done  (core_done),
      .rsp   (core_rsp),
      .take  (core_take)
   );

   // output register frees the core as soon as it can hold the item
   assign core_take = core_done && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      rsp_in = rsp_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      if (core_take) begin
         rsp_in = core_rsp;
         rsp_tvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = RSP_DATA_W'({rsp_ff.occupancy, rsp_ff.value});
   assign rsp_tuser = rsp_ff.status;

endmodule

>>> test/max_heap_priority_queue_unit_test.sv
// testbench for max_heap_priority_queue_unit: drives insert, extract, read-max and unused-command items
// and checks every result against a heap predictor held in a small scoreboard class
// depends on mhpq_pkg and the max_heap_priority_queue_unit rtl
`timescale 1ns / 1ps

module max_heap_priority_queue_unit_test;
   import mhpq_pkg::*;

   // unused command code, the block treats it as no operation
   localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
   localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
   localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
   localparam int CYCLE_LIMIT = 1000000;

   class heap_scoreboard;
      logic signed [KEY_W-1:0] heap_keys [CAPACITY];
      int unsigned held = 0;
      rsp_type pending [$];
      int errors = 0;

      // runs one command on the predicted heap and queues the result it should give
      function void note_request(logic [CMD_W-1:0] cmd, logic signed [KEY_W-1:0] key);
         rsp_type r;
         int unsigned pos;
         int unsigned parent;
         int unsigned best;
         int unsigned left;
         int unsigned right;
         logic signed [KEY_W-1:0] t;
         r.value = '0;
         r.status = ST_OK;
         case (cmd)
            CMD_INSERT: begin
               if (held >= CAPACITY) begin
                  r.status = ST_FULL;
               end else begin
                  heap_keys[held] = key;
                  pos = held;
                  held++;
                  while (pos > 0) begin
                     parent = (pos - 1) / 2;
                     if (heap_keys[parent] >= heap_keys[pos]) break;
                     t = heap_keys[parent];
                     heap_keys[parent] = heap_keys[pos];
                     heap_keys[pos] = t;
                     pos = parent;
                  end
               end
            end
            CMD_EXTRACT: begin
               if (held == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  r.value = heap_keys[0];
                  held--;
                  heap_keys[0] = heap_keys[held];
                  pos = 0;
                  // a child wins only if strictly greater, left first on a tie
                  while (pos < held) begin
                     best = pos;
                     left = 2 * pos + 1;
                     right = 2 * pos + 2;
                     if (left < held && heap_keys[left] > heap_keys[best]) best = left;
                     if (right < held && heap_keys[right] > heap_keys[best]) best = right;
                     if (best == pos) break;
                     t = heap_keys[pos];
                     heap_keys[pos] = heap_keys[best];
                     heap_keys[best] = t;
                     pos = best;
                  end
               end
            end
            CMD_READ_MAX: begin
               if (held == 0) r.status = ST_EMPTY;
               else r.value = heap_keys[0];
            end
            default: begin
            end
         endcase
         r.occupancy = CNT_W'(held);
         pending = {pending, r};
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] data, logic [STATUS_W-1:0] status);
         rsp_type want;
         logic signed [KEY_W-1:0] got_value;
         logic [CNT_W-1:0] got_occupancy;
         got_value = data[KEY_W-1:0];
         got_occupancy = data[KEY_W+CNT_W-1:KEY_W];
         if (pending.size() == 0) begin
            $display("%0t: unexpected result item value %0d status %0d occupancy %0d",
                     $time, got_value, status, got_occupancy);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got_value !== want.value) begin
            $display("%0t: value mismatch, expected %0d actual %0d",
                     $time, want.value, got_value);
            errors++;
         end
         if (status !== want.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, status);
            errors++;
         end
         if (got_occupancy !== want.occupancy) begin
            $display("%0t: occupancy mismatch, expected %0d actual %0d",
                     $time, want.occupancy, got_occupancy);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0; // [31:0] key
   logic [CMD_W-1:0] req_tuser = '0;      // [1:0] cmd
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;      // [31:0] value, [42:32] occupancy
   logic [STATUS_W-1:0] rsp_tuser;        // [1:0] status

   heap_scoreboard sb = new;
   bit no_idle = 1'b0;
   int cycle_count = 0;

   max_heap_priority_queue_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [KEY_W-1:0] rand_key();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 3))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return '0;
            default: return '1;
         endcase
      end
      // narrow range so equal keys meet in the heap
      if (r <= 3) return $signed($urandom_range(0, 8)) - 4;
      return $urandom;
   endfunction

   function automatic logic [CMD_W-1:0] pick_cmd(int ins, int ext, int rd);
      int r;
      r = $urandom_range(0, 99);
      if (r < ins) return CMD_INSERT;
      if (r < ins + ext) return CMD_EXTRACT;
      if (r < ins + ext + rd) return CMD_READ_MAX;
      return CMD_NOP;
   endfunction

   task automatic send_op(input logic [CMD_W-1:0] cmd, input logic signed [KEY_W-1:0] key);
      int gap;
      gap = no_idle ? 0 : gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= key;
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, key);
   endtask

   initial begin : rsp_sink
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0) stall = gap_len();
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty heap, extremes, ties, then drain past empty
      send_op(CMD_READ_MAX, $urandom);
      send_op(CMD_EXTRACT, $urandom);
      send_op(CMD_NOP, $urandom);
      send_op(CMD_INSERT, KEY_MIN);
      send_op(CMD_READ_MAX, $urandom);
      send_op(CMD_INSERT, KEY_MAX);
      send_op(CMD_INSERT, '0);
      send_op(CMD_INSERT, '1);
      send_op(CMD_INSERT, 5);
      send_op(CMD_INSERT, 5);
      send_op(CMD_INSERT, 5);
      send_op(CMD_NOP, $urandom);
      send_op(CMD_READ_MAX, $urandom);
      send_op(CMD_INSERT, KEY_MAX);
      repeat (8) send_op(CMD_EXTRACT, $urandom);
      send_op(CMD_EXTRACT, $urandom);
      send_op(CMD_READ_MAX, $urandom);

      // mixed traffic, the first stretch without idling
      no_idle = 1'b1;
      for (int i = 0; i < 300; i++) begin
         if (i == 100) no_idle = 1'b0;
         send_op(pick_cmd(55, 30, 10), rand_key());
      end

      // fill to capacity, then hit the full heap
      while (sb.held < CAPACITY) send_op(pick_cmd(90, 3, 5), rand_key());
      repeat (12) send_op(pick_cmd(70, 0, 20), rand_key());

      // mostly extracts from the big heap
      for (int i = 0; i < 350; i++) begin
         no_idle = (i >= 150 && i < 220);
         send_op(pick_cmd(10, 75, 10), rand_key());
      end
      no_idle = 1'b0;
      req_tvalid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
